// ===== rtl/core/bidirectional_flow_table_defines.svh =====
// Assertion helpers shared by the flow table RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef BIDIRECTIONAL_FLOW_TABLE_DEFINES_SVH
`define BIDIRECTIONAL_FLOW_TABLE_DEFINES_SVH

// Clocked check, muted while reset is asserted.
`define BFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication built on the check above.
`define BFT_ASSERT_IMPLY(label, cond, conseq, msg) \
    `BFT_ASSERT(label, (cond) |-> (conseq), msg)

`endif

// ===== rtl/core/bft_pkg.sv =====
package bft_pkg;

    localparam int FLOW_ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam int ID_W   = 6;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int SIZE_W = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
    } key_t;

    typedef struct packed {
        logic              is_update;
        key_t              key;
        logic [ID_W-1:0]   target_flow;
        logic [SIZE_W-1:0] buffer_size;
        logic              direction_in;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } queue_if_t;

endpackage

// ===== rtl/core/bft_ram.sv =====
module bft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bft_front.sv =====
`include "bidirectional_flow_table_defines.svh"

module bft_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [bft_pkg::ADDR_W-1:0]  src_addr,
    input  logic [bft_pkg::ADDR_W-1:0]  dst_addr,
    input  logic [bft_pkg::PORT_W-1:0]  src_port,
    input  logic [bft_pkg::PORT_W-1:0]  dst_port,
    input  logic [bft_pkg::ID_W-1:0]    target_flow,
    input  logic [bft_pkg::SIZE_W-1:0]  buffer_size,
    input  logic                        direction_in,
    output bft_pkg::queue_if_t          q_out,
    input  logic                        q_pop
);

    bft_pkg::req_t                 slot_reg [bft_pkg::QUEUE_DEPTH];
    logic [bft_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bft_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bft_pkg::QCNT_W-1:0]    fill_reg, fill_next;
    bft_pkg::req_t                 new_req;
    logic                          push;

    // Classify the request and pack it for the back end.
    always_comb
    begin
        new_req.is_update     = (opcode == bft_pkg::OP_UPDATE);
        new_req.key.src_addr  = src_addr;
        new_req.key.dst_addr  = dst_addr;
        new_req.key.src_port  = src_port;
        new_req.key.dst_port  = dst_port;
        new_req.target_flow   = target_flow;
        new_req.buffer_size   = buffer_size;
        new_req.direction_in  = direction_in;
    end

    assign in_ready = (fill_reg != bft_pkg::QCNT_W'(bft_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == bft_pkg::QPTR_W'(bft_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == bft_pkg::QPTR_W'(bft_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_req;
        end
    end

    assign q_out.valid = (fill_reg != '0);
    assign q_out.req   = slot_reg[rd_ptr_reg];

    `BFT_ASSERT_IMPLY(a_pop_nonempty, q_pop, fill_reg != '0, "pop from empty request queue")
    `BFT_ASSERT(a_fill_bound, fill_reg <= bft_pkg::QCNT_W'(bft_pkg::QUEUE_DEPTH),
        "request queue overfilled")

endmodule

// ===== rtl/core/bft_back.sv =====
`include "bidirectional_flow_table_defines.svh"

module bft_back #(
    parameter int FLOW_ENTRIES = bft_pkg::FLOW_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bft_pkg::queue_if_t          q_in,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bft_pkg::ID_W-1:0]    flow_id,
    output logic                        is_new,
    output logic                        table_full,
    output logic                        hit,
    output logic [bft_pkg::SIZE_W-1:0]  total_in_size,
    output logic [bft_pkg::SIZE_W-1:0]  total_out_size
);

    localparam int IDX_W = $clog2(FLOW_ENTRIES);
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam int KEY_W = $bits(bft_pkg::key_t);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]                state_reg, state_next;
    bft_pkg::req_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;
    logic                      cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [bft_pkg::SIZE_W-1:0] sum_in_reg, sum_in_next;
    logic [bft_pkg::SIZE_W-1:0] sum_out_reg, sum_out_next;
    logic                      out_valid_reg, out_valid_next;
    logic [bft_pkg::ID_W-1:0]  flow_id_reg, flow_id_next;
    logic                      is_new_reg, is_new_next;
    logic                      full_reg, full_next;
    logic                      hit_reg, hit_next;

    logic                      start;
    logic                      tgt_ok;
    logic                      key_rd_en;
    logic                      key_wr_en;
    bft_pkg::key_t             key_rd_data;
    logic [KEY_W-1:0]          key_rd_raw;
    logic                      match;
    logic                      size_rd_en;
    logic [IDX_W-1:0]          size_rd_addr;
    logic [IDX_W-1:0]          size_wr_addr;
    logic                      in_wr_en, out_wr_en;
    logic [bft_pkg::SIZE_W-1:0] size_wr_data;
    logic [bft_pkg::SIZE_W-1:0] in_rd_data, out_rd_data;
    logic [bft_pkg::SIZE_W-1:0] old_size;
    logic [bft_pkg::SIZE_W-1:0] new_sum;

    assign key_rd_data = bft_pkg::key_t'(key_rd_raw);

    // Take a request only when the result register is free or drains now.
    assign start  = (state_reg == ST_IDLE) && q_in.valid && (!out_valid_reg || out_ready);
    assign q_pop  = start;
    assign tgt_ok = 32'(q_in.req.target_flow) < 32'(count_reg);

    assign key_rd_en = (state_reg == ST_SCAN) && (issue_reg < count_reg);

    // Match as given or with source and destination swapped.
    always_comb
    begin
        match = ((key_rd_data.src_addr == cmd_reg.key.src_addr) &&
                 (key_rd_data.dst_addr == cmd_reg.key.dst_addr) &&
                 (key_rd_data.src_port == cmd_reg.key.src_port) &&
                 (key_rd_data.dst_port == cmd_reg.key.dst_port)) ||
                ((key_rd_data.src_addr == cmd_reg.key.dst_addr) &&
                 (key_rd_data.dst_addr == cmd_reg.key.src_addr) &&
                 (key_rd_data.src_port == cmd_reg.key.dst_port) &&
                 (key_rd_data.dst_port == cmd_reg.key.src_port));
    end

    assign size_rd_en   = start && q_in.req.is_update && tgt_ok;
    assign size_rd_addr = IDX_W'(q_in.req.target_flow);
    assign old_size     = cmd_reg.direction_in ? in_rd_data : out_rd_data;
    assign new_sum      = (cmd_reg.direction_in ? sum_in_reg : sum_out_reg) - old_size
                          + cmd_reg.buffer_size;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        sum_in_next    = sum_in_reg;
        sum_out_next   = sum_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        flow_id_next   = flow_id_reg;
        is_new_next    = is_new_reg;
        full_next      = full_reg;
        hit_next       = hit_reg;
        key_wr_en      = 1'b0;
        in_wr_en       = 1'b0;
        out_wr_en      = 1'b0;
        size_wr_addr   = count_reg[IDX_W-1:0];
        size_wr_data   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = q_in.req;
                    if (!q_in.req.is_update)
                    begin
                        issue_next = '0;
                        state_next = ST_SCAN;
                    end
                    else if (tgt_ok)
                    begin
                        state_next = ST_UPD;
                    end
                    else
                    begin
                        // Unknown id: drop the update and report a miss.
                        out_valid_next = 1'b1;
                        flow_id_next   = '0;
                        is_new_next    = 1'b0;
                        full_next      = 1'b0;
                        hit_next       = 1'b0;
                    end
                end
            end

            ST_SCAN:
            begin
                if (key_rd_en)
                begin
                    issue_next     = issue_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                end
                if (cmp_valid_reg && match)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    flow_id_next   = bft_pkg::ID_W'(cmp_idx_reg);
                    is_new_next    = 1'b0;
                    full_next      = 1'b0;
                    hit_next       = 1'b1;
                end
                else if (!key_rd_en)
                begin
                    // Every stored key compared without a match.
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    if (count_reg < CNT_W'(FLOW_ENTRIES))
                    begin
                        key_wr_en    = 1'b1;
                        in_wr_en     = 1'b1;
                        out_wr_en    = 1'b1;
                        count_next   = count_reg + 1'b1;
                        flow_id_next = bft_pkg::ID_W'(count_reg);
                        is_new_next  = 1'b1;
                        full_next    = 1'b0;
                    end
                    else
                    begin
                        flow_id_next = '0;
                        is_new_next  = 1'b0;
                        full_next    = 1'b1;
                    end
                end
            end

            ST_UPD:
            begin
                size_wr_addr = IDX_W'(cmd_reg.target_flow);
                size_wr_data = cmd_reg.buffer_size;
                if (cmd_reg.direction_in)
                begin
                    in_wr_en    = 1'b1;
                    sum_in_next = new_sum;
                end
                else
                begin
                    out_wr_en    = 1'b1;
                    sum_out_next = new_sum;
                end
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                flow_id_next   = cmd_reg.target_flow;
                is_new_next    = 1'b0;
                full_next      = 1'b0;
                hit_next       = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            sum_in_reg    <= '0;
            sum_out_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            sum_in_reg    <= sum_in_next;
            sum_out_reg   <= sum_out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        flow_id_reg <= flow_id_next;
        is_new_reg  <= is_new_next;
        full_reg    <= full_next;
        hit_reg     <= hit_next;
    end

    bft_ram #(
        .WIDTH (KEY_W),
        .DEPTH (FLOW_ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (KEY_W'(cmd_reg.key)),
        .rd_en   (key_rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (key_rd_raw)
    );

    bft_ram #(
        .WIDTH (bft_pkg::SIZE_W),
        .DEPTH (FLOW_ENTRIES)
    ) u_in_ram (
        .clk     (clk),
        .wr_en   (in_wr_en),
        .wr_addr (size_wr_addr),
        .wr_data (size_wr_data),
        .rd_en   (size_rd_en),
        .rd_addr (size_rd_addr),
        .rd_data (in_rd_data)
    );

    bft_ram #(
        .WIDTH (bft_pkg::SIZE_W),
        .DEPTH (FLOW_ENTRIES)
    ) u_out_ram (
        .clk     (clk),
        .wr_en   (out_wr_en),
        .wr_addr (size_wr_addr),
        .wr_data (size_wr_data),
        .rd_en   (size_rd_en),
        .rd_addr (size_rd_addr),
        .rd_data (out_rd_data)
    );

    assign out_valid      = out_valid_reg;
    assign flow_id        = flow_id_reg;
    assign is_new         = is_new_reg;
    assign table_full     = full_reg;
    assign hit            = hit_reg;
    assign total_in_size  = sum_in_reg;
    assign total_out_size = sum_out_reg;

    `BFT_ASSERT(a_count_bound, count_reg <= CNT_W'(FLOW_ENTRIES), "flow count above capacity")
    `BFT_ASSERT_IMPLY(a_busy_out_free, state_reg != ST_IDLE, !out_valid_reg,
        "engine busy while a result is pending")
    `BFT_ASSERT_IMPLY(a_full_at_cap, out_valid_reg && full_reg, count_reg == CNT_W'(FLOW_ENTRIES),
        "table_full reported below capacity")
    `BFT_ASSERT_IMPLY(a_new_excl_hit, out_valid_reg && is_new_reg, !hit_reg && !full_reg,
        "insert reported together with hit or full")

endmodule

// ===== rtl/core/bidirectional_flow_table.sv =====
// Bidirectional flow table: up to FLOW_ENTRIES connections keyed on source and
// destination address and port. A lookup request (opcode 0) matches a stored key
// as given or with source and destination swapped; the lowest matching id wins.
// On a miss the key is appended at the next free id with zero in/out sizes, or
// table_full is raised when all FLOW_ENTRIES ids are taken. An update request
// (opcode 1) sets the in or out size of target_flow; an id that was never
// assigned is ignored and reported with hit 0. Every result carries the running
// totals of all in and out sizes, wrapping modulo 2^32. Requests enter a
// two-deep queue, so the input stays ready until two requests wait there. The
// back end walks the key memory one stored flow per cycle and stops a lookup
// at the first match or after the last stored key; an update reads the size
// memory, then writes back and adjusts the total, and an update of an unknown
// id is answered without touching the memories. One request is in the back
// end at a time. Keys and sizes live in single-port-write RAMs with registered
// reads; no clearing pass follows reset.
module bidirectional_flow_table #(
    parameter int FLOW_ENTRIES = bft_pkg::FLOW_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    // Request channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic [bft_pkg::ADDR_W-1:0]  src_addr,
    input  logic [bft_pkg::ADDR_W-1:0]  dst_addr,
    input  logic [bft_pkg::PORT_W-1:0]  src_port,
    input  logic [bft_pkg::PORT_W-1:0]  dst_port,
    input  logic [bft_pkg::ID_W-1:0]    target_flow,
    input  logic [bft_pkg::SIZE_W-1:0]  buffer_size,
    input  logic                        direction_in,

    // Result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bft_pkg::ID_W-1:0]    flow_id,
    output logic                        is_new,
    output logic                        table_full,
    output logic                        hit,
    output logic [bft_pkg::SIZE_W-1:0]  total_in_size,
    output logic [bft_pkg::SIZE_W-1:0]  total_out_size
);

    // Classified requests waiting for the table engine.
    bft_pkg::queue_if_t q_link;
    logic               q_pop;

    // Front end: accept, classify and hold requests.
    bft_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .src_port     (src_port),
        .dst_port     (dst_port),
        .target_flow  (target_flow),
        .buffer_size  (buffer_size),
        .direction_in (direction_in),
        .q_out        (q_link),
        .q_pop        (q_pop)
    );

    // Back end: scan keys, insert, update sizes, hold the result register.
    bft_back #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_in           (q_link),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .flow_id        (flow_id),
        .is_new         (is_new),
        .table_full     (table_full),
        .hit            (hit),
        .total_in_size  (total_in_size),
        .total_out_size (total_out_size)
    );

endmodule

// ===== dv/testbench.sv =====
module testbench;

    import bft_pkg::*;

    localparam int TABLE_SIZE  = FLOW_ENTRIES_DEF;
    localparam int RANDOM_REQS = 1025;
    localparam int MAX_GAP     = 16;
    localparam int SETTLE_CYC  = 80;   // longest lookup walk plus slack

    // One queued request: the payload, the idle cycles before it goes out, and
    // whether the sender must wait for every outstanding result first.
    typedef struct {
        req_t req;
        int   gap;
        bit   drain;
    } flow_request_t;

    typedef struct packed {
        logic [ID_W-1:0]   flow_id;
        logic              is_new;
        logic              table_full;
        logic              hit;
        logic [SIZE_W-1:0] total_in;
        logic [SIZE_W-1:0] total_out;
    } flow_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Every input starts at a known value; the driver takes over after reset.
    logic              in_valid     = 1'b0;
    logic              in_ready;
    logic              opcode       = OP_LOOKUP;
    logic [ADDR_W-1:0] src_addr     = '0;
    logic [ADDR_W-1:0] dst_addr     = '0;
    logic [PORT_W-1:0] src_port     = '0;
    logic [PORT_W-1:0] dst_port     = '0;
    logic [ID_W-1:0]   target_flow  = '0;
    logic [SIZE_W-1:0] buffer_size  = '0;
    logic              direction_in = 1'b0;

    logic              out_valid;
    logic              out_ready    = 1'b0;
    logic [ID_W-1:0]   flow_id;
    logic              is_new;
    logic              table_full;
    logic              hit;
    logic [SIZE_W-1:0] total_in_size;
    logic [SIZE_W-1:0] total_out_size;

    bidirectional_flow_table #(
        .FLOW_ENTRIES (TABLE_SIZE)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .src_addr       (src_addr),
        .dst_addr       (dst_addr),
        .src_port       (src_port),
        .dst_port       (dst_port),
        .target_flow    (target_flow),
        .buffer_size    (buffer_size),
        .direction_in   (direction_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .flow_id        (flow_id),
        .is_new         (is_new),
        .table_full     (table_full),
        .hit            (hit),
        .total_in_size  (total_in_size),
        .total_out_size (total_out_size)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hold reset low from time zero, then release it for good.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Flow table tracker: our own copy of the keys, sizes and totals.
    // ------------------------------------------------------------------
    key_t              flow_keys [TABLE_SIZE];
    logic [SIZE_W-1:0] in_sizes  [TABLE_SIZE];
    logic [SIZE_W-1:0] out_sizes [TABLE_SIZE];
    int                flow_count = 0;
    logic [SIZE_W-1:0] in_total   = '0;
    logic [SIZE_W-1:0] out_total  = '0;
    flow_result_t      expected_results [$];

    int n_errors = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        n_errors++;
    endtask

    function automatic key_t swap_key(input key_t k);
        key_t r;
        r.src_addr = k.dst_addr;
        r.dst_addr = k.src_addr;
        r.src_port = k.dst_port;
        r.dst_port = k.src_port;
        return r;
    endfunction

    // A stored key matches a request key as given or with the ends swapped.
    function automatic bit same_flow(input key_t stored, input key_t k);
        return (stored == k) || (stored == swap_key(k));
    endfunction

    // Apply one accepted request to the tracked table and queue its result.
    task automatic track_request(input req_t r);
        flow_result_t res;
        int           match;
        int           t;
        res   = '0;
        match = -1;
        t     = int'(r.target_flow);
        if (r.is_update == OP_LOOKUP)
        begin
            // The lowest matching id wins; only live entries are searched.
            for (int i = 0; i < flow_count && match < 0; i++)
                if (same_flow(flow_keys[i], r.key))
                    match = i;
            if (match >= 0)
            begin
                res.flow_id = ID_W'(match);
                res.hit     = 1'b1;
            end
            else if (flow_count < TABLE_SIZE)
            begin
                // Append at the next free id with both sizes cleared.
                flow_keys[flow_count] = r.key;
                in_sizes[flow_count]  = '0;
                out_sizes[flow_count] = '0;
                res.flow_id           = ID_W'(flow_count);
                res.is_new            = 1'b1;
                flow_count++;
            end
            else
                res.table_full = 1'b1;
        end
        else if (t < flow_count)
        begin
            // Replace the old size in the running total, wrapping at 32 bits.
            if (r.direction_in)
            begin
                in_total    = in_total - in_sizes[t] + r.buffer_size;
                in_sizes[t] = r.buffer_size;
            end
            else
            begin
                out_total    = out_total - out_sizes[t] + r.buffer_size;
                out_sizes[t] = r.buffer_size;
            end
            res.flow_id = r.target_flow;
            res.hit     = 1'b1;
        end
        // An update of an id never assigned is dropped: all flags stay zero.
        res.total_in     = in_total;
        res.total_out    = out_total;
        expected_results = {expected_results, res};
    endtask

    // ------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------
    flow_request_t pending [$];
    key_t          issued_keys [$];   // every distinct flow ever looked up
    bit            quiet_stretch = 1'b0;

    function automatic key_t make_key(input logic [ADDR_W-1:0] sa,
                                      input logic [ADDR_W-1:0] da,
                                      input logic [PORT_W-1:0] sp,
                                      input logic [PORT_W-1:0] dp);
        key_t k;
        k.src_addr = sa;
        k.dst_addr = da;
        k.src_port = sp;
        k.dst_port = dp;
        return k;
    endfunction

    function automatic key_t random_key();
        return make_key($urandom, $urandom, PORT_W'($urandom), PORT_W'($urandom));
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 3))
            0:       return '1;
            1:       return SIZE_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(input req_t r, input bit drain);
        flow_request_t item;
        item.req   = r;
        item.drain = drain;
        item.gap   = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
        pending    = {pending, item};
    endtask

    // Fill the fields a lookup ignores with noise so they toggle too.
    task automatic queue_lookup(input key_t k, input bit drain);
        req_t r;
        bit   known;
        r.is_update    = OP_LOOKUP;
        r.key          = k;
        r.target_flow  = ID_W'($urandom);
        r.buffer_size  = $urandom;
        r.direction_in = 1'($urandom_range(0, 1));
        known          = 1'b0;
        foreach (issued_keys[i])
            if (same_flow(issued_keys[i], k))
                known = 1'b1;
        if (!known)
            issued_keys = {issued_keys, k};
        queue_request(r, drain);
    endtask

    task automatic queue_update(input logic [ID_W-1:0]   id,
                                input logic [SIZE_W-1:0] size,
                                input logic              dir_in);
        req_t r;
        r.is_update    = OP_UPDATE;
        r.key          = random_key();
        r.target_flow  = id;
        r.buffer_size  = size;
        r.direction_in = dir_in;
        queue_request(r, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued requests, count acceptances, run the tracker.
    // ------------------------------------------------------------------
    req_t cur_req;
    int   idle_cycles;
    int   n_accepted;
    int   n_checked;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            idle_cycles <= 0;
            n_accepted  <= 0;
        end
        else
        begin
            bit            took;
            int            waited;
            flow_request_t nxt;
            took   = in_valid && in_ready;
            waited = took ? 0 : idle_cycles;
            if (took)
            begin
                track_request(cur_req);
                n_accepted <= n_accepted + 1;
            end
            // Hold a request that is still waiting for ready.
            if (!in_valid || took)
            begin
                // A draining request waits until every result is back.
                if (pending.size() != 0 && waited >= pending[0].gap &&
                    (!pending[0].drain || (!took && n_checked == n_accepted)))
                begin
                    nxt          = pending.pop_front();
                    cur_req      <= nxt.req;
                    opcode       <= nxt.req.is_update;
                    src_addr     <= nxt.req.key.src_addr;
                    dst_addr     <= nxt.req.key.dst_addr;
                    src_port     <= nxt.req.key.src_port;
                    dst_port     <= nxt.req.key.dst_port;
                    target_flow  <= nxt.req.target_flow;
                    buffer_size  <= nxt.req.buffer_size;
                    direction_in <= nxt.req.direction_in;
                    in_valid     <= 1'b1;
                    idle_cycles  <= 0;
                end
                else
                begin
                    in_valid    <= 1'b0;
                    idle_cycles <= waited + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the result side at random and check every result.
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            n_checked  <= 0;
        end
        else
        begin
            flow_result_t want;
            int           stall;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                              n_checked));
                else
                begin
                    want = expected_results.pop_front();
                    if (flow_id !== want.flow_id)
                        report_mismatch($sformatf("result %0d flow_id got %0d want %0d",
                                                  n_checked, flow_id, want.flow_id));
                    if (is_new !== want.is_new)
                        report_mismatch($sformatf("result %0d is_new got %b want %b",
                                                  n_checked, is_new, want.is_new));
                    if (table_full !== want.table_full)
                        report_mismatch($sformatf("result %0d table_full got %b want %b",
                                                  n_checked, table_full, want.table_full));
                    if (hit !== want.hit)
                        report_mismatch($sformatf("result %0d hit got %b want %b",
                                                  n_checked, hit, want.hit));
                    if (total_in_size !== want.total_in)
                        report_mismatch($sformatf("result %0d total_in_size got %h want %h",
                                                  n_checked, total_in_size, want.total_in));
                    if (total_out_size !== want.total_out)
                        report_mismatch($sformatf("result %0d total_out_size got %h want %h",
                                                  n_checked, total_out_size, want.total_out));
                end
                n_checked <= n_checked + 1;
                // Draw a stall for the next result; leave stretches without any.
                stall      = (n_checked % 300 >= 150) ? 0 : $urandom_range(0, MAX_GAP);
                out_ready  <= (stall == 0);
                stall_left <= stall;
            end
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= (stall_left == 1);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        key_t k;
        int   n_live;
        int   pick;

        // Directed: updates on an empty table, inserts, forward and swapped
        // hits, a half-swapped key that must miss, sums that wrap, size
        // replacement, unknown ids at the next free id and beyond.
        queue_update(ID_W'(0), '1, 1'b1);
        queue_update('1, SIZE_W'(1), 1'b0);
        queue_lookup(make_key('0, '0, '0, '0), 1'b0);
        queue_lookup(make_key('1, '1, '1, '1), 1'b0);
        queue_lookup(make_key('0, '0, '0, '0), 1'b0);
        k = make_key(32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80);
        queue_lookup(k, 1'b0);
        queue_lookup(swap_key(k), 1'b0);
        queue_lookup(make_key(k.dst_addr, k.src_addr, k.src_port, k.dst_port), 1'b0);
        k = make_key('1, '0, '1, '0);
        queue_lookup(k, 1'b0);
        queue_lookup(swap_key(k), 1'b0);
        queue_update(ID_W'(5), SIZE_W'(7), 1'b1);
        queue_update(ID_W'(4), '1, 1'b1);
        queue_update(ID_W'(0), '1, 1'b1);
        queue_update(ID_W'(1), SIZE_W'(2), 1'b1);
        queue_update(ID_W'(4), '0, 1'b1);
        queue_update(ID_W'(2), 32'h8000_0000, 1'b0);
        queue_update(ID_W'(3), 32'h8000_0000, 1'b0);
        queue_update(ID_W'(3), '0, 1'b0);
        queue_update('1, SIZE_W'(5), 1'b1);
        queue_update(ID_W'(1), '1, 1'b0);
        queue_lookup(swap_key(make_key('1, '1, '1, '1)), 1'b0);
        // Symmetric key, sent only after the block has gone fully idle.
        k = make_key(32'h1234_5678, 32'h1234_5678, 16'd7, 16'd7);
        queue_lookup(k, 1'b1);
        queue_lookup(k, 1'b0);

        // Random: mostly hits on known flows and updates of live ids, a
        // trickle of new flows that fills the table part way through, and
        // near-miss keys plus updates of arbitrary ids as noise.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            quiet_stretch = (i % 300) >= 200;
            n_live        = (issued_keys.size() < TABLE_SIZE) ? issued_keys.size()
                                                              : TABLE_SIZE;
            pick          = $urandom_range(0, 99);
            if (pick < 40)
            begin
                k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
                queue_lookup($urandom_range(0, 1) ? swap_key(k) : k, i == RANDOM_REQS / 2);
            end
            else if (pick < 48)
                queue_lookup(random_key(), 1'b0);
            else if (pick < 54)
            begin
                // Break one field of a known key.
                k = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
                case ($urandom_range(0, 3))
                    0: k.src_addr = $urandom;
                    1: k.dst_addr = $urandom;
                    2: k.src_port = PORT_W'($urandom);
                    default: k.dst_port = PORT_W'($urandom);
                endcase
                queue_lookup(k, 1'b0);
            end
            else if (pick < 90)
                queue_update(ID_W'($urandom_range(0, n_live - 1)), random_size(),
                             1'($urandom_range(0, 1)));
            else
                queue_update(ID_W'($urandom), random_size(), 1'($urandom_range(0, 1)));
        end

        // Drain: wait for the last request and its result, then settle.
        while (pending.size() != 0 || in_valid || n_checked != n_accepted)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
